/* sv/lsfd_pkg.sv */
// Package for the LIFO stack with filtered dump.
// Holds sizes, operation codes and status codes; depends on nothing.
package lsfd_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int WORD_BITS   = 32;
  localparam int ADDR_BITS   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_BITS  = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH          = 3'd0,
    OP_POP           = 3'd1,
    OP_DUMP_ALL      = 3'd2,
    OP_DUMP_EVEN_POS = 3'd3,
    OP_DUMP_EVEN_VAL = 3'd4,
    OP_SIZE          = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2,
    ST_DUMP_NONE = 2'd3
  } status_t;

endpackage

/* sv/lsfd_ram.sv */
// Simple dual-port synchronous RAM with one write and one registered read port.
// Generic; the read data holds while no read is issued. No dependencies.
module lsfd_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/lifo_stack_with_filtered_dump.sv */
// Bounded LIFO stack of signed words with push, pop, size and three top-first dumps
// (all entries, even positions from the top, even values). Push and size answer
// directly, a pop after one RAM read, and a dump after a walk that reads one entry per
// cycle through the single RAM read port; a stalled output slows the walk. Every
// request gives one word except a dump, which gives one word per listed entry, or a
// single word with the nothing-found status. Codes 6 and 7 are dropped without a
// word. Uses lsfd_pkg and lsfd_ram.
module lifo_stack_with_filtered_dump (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       in_func,
  input  logic signed [lsfd_pkg::WORD_BITS-1:0] in_push_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [lsfd_pkg::WORD_BITS-1:0] out_value,
  output logic [lsfd_pkg::DEPTH_BITS-1:0]  out_depth_now,
  output logic [1:0]                       out_status,
  output logic                             out_last
);
  import lsfd_pkg::*;

  localparam logic [DEPTH_BITS-1:0] DEPTH_FULL = DEPTH_BITS'(STACK_DEPTH);
  localparam logic [DEPTH_BITS-1:0] ONE        = DEPTH_BITS'(1);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_DUMP, S_END} state_t;

  state_t                 state_r, state_nxt;
  logic [DEPTH_BITS-1:0]  depth_r, depth_nxt;
  logic [DEPTH_BITS-1:0]  iss_r, iss_nxt;
  logic                   dv_r, dv_nxt;
  logic                   dpar_r, dpar_nxt;
  logic [2:0]             mode_r, mode_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  logic [WORD_BITS-1:0]   pend_value_r, pend_value_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0]   out_value_r, out_value_nxt;
  logic [DEPTH_BITS-1:0]  out_depth_r, out_depth_nxt;
  logic [1:0]             out_status_r, out_status_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   we, re;
  logic [ADDR_BITS-1:0]   waddr, raddr;
  logic [WORD_BITS-1:0]   rdata;
  logic                   out_free, in_acc, take, stall;
  logic [DEPTH_BITS-1:0]  top_idx, walk_idx;

  lsfd_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_push_value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;
  assign top_idx  = depth_r - ONE;
  assign walk_idx = depth_r - ONE - iss_r;
  assign waddr    = depth_r[ADDR_BITS-1:0];

  always_comb begin
    case (mode_r)
      OP_DUMP_ALL:      take = 1'b1;
      OP_DUMP_EVEN_POS: take = dpar_r;
      OP_DUMP_EVEN_VAL: take = !rdata[0];
      default:          take = 1'b0;
    endcase
  end

  assign stall = dv_r && take && pend_valid_r && !out_free;

  always_comb begin
    state_nxt      = state_r;
    depth_nxt      = depth_r;
    iss_nxt        = iss_r;
    dv_nxt         = dv_r;
    dpar_nxt       = dpar_r;
    mode_nxt       = mode_r;
    pend_valid_nxt = pend_valid_r;
    pend_value_nxt = pend_value_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_depth_nxt  = out_depth_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    we             = 1'b0;
    re             = 1'b0;
    raddr          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_func)
            OP_PUSH: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              out_last_nxt  = 1'b1;
              if (depth_r >= DEPTH_FULL) begin
                out_status_nxt = ST_PUSH_FULL;
                out_depth_nxt  = depth_r;
              end else begin
                we             = 1'b1;
                depth_nxt      = depth_r + ONE;
                out_status_nxt = ST_OK;
                out_depth_nxt  = depth_r + ONE;
              end
            end
            OP_POP: begin
              if (depth_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_last_nxt   = 1'b1;
                out_status_nxt = ST_POP_EMPTY;
                out_depth_nxt  = depth_r;
              end else begin
                re        = 1'b1;
                raddr     = top_idx[ADDR_BITS-1:0];
                depth_nxt = top_idx;
                state_nxt = S_POP;
              end
            end
            OP_SIZE: begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = '0;
              out_last_nxt   = 1'b1;
              out_status_nxt = ST_OK;
              out_depth_nxt  = depth_r;
            end
            OP_DUMP_ALL, OP_DUMP_EVEN_POS, OP_DUMP_EVEN_VAL: begin
              mode_nxt       = in_func;
              iss_nxt        = '0;
              dv_nxt         = 1'b0;
              pend_valid_nxt = 1'b0;
              state_nxt      = S_DUMP;
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = rdata;
        out_last_nxt   = 1'b1;
        out_status_nxt = ST_OK;
        out_depth_nxt  = depth_r;
        state_nxt      = S_IDLE;
      end
      S_DUMP: begin
        if (!stall) begin
          if (dv_r && take) begin
            if (pend_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = pend_value_r;
              out_last_nxt   = 1'b0;
              out_status_nxt = ST_OK;
              out_depth_nxt  = depth_r;
            end
            pend_valid_nxt = 1'b1;
            pend_value_nxt = rdata;
          end
          if (iss_r < depth_r) begin
            re       = 1'b1;
            raddr    = walk_idx[ADDR_BITS-1:0];
            iss_nxt  = iss_r + ONE;
            dv_nxt   = 1'b1;
            dpar_nxt = iss_r[0];
          end else begin
            dv_nxt    = 1'b0;
            state_nxt = S_END;
          end
        end
      end
      S_END: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = pend_valid_r ? pend_value_r : '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = pend_valid_r ? ST_OK : ST_DUMP_NONE;
          out_depth_nxt  = depth_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      depth_r      <= '0;
      iss_r        <= '0;
      dv_r         <= 1'b0;
      dpar_r       <= 1'b0;
      mode_r       <= OP_DUMP_ALL;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      depth_r      <= depth_nxt;
      iss_r        <= iss_nxt;
      dv_r         <= dv_nxt;
      dpar_r       <= dpar_nxt;
      mode_r       <= mode_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_value_r <= pend_value_nxt;
    out_value_r  <= out_value_nxt;
    out_depth_r  <= out_depth_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_depth_now = out_depth_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

  // The depth never passes the capacity, and the walk never reads past it.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_FULL)
    else $error("stack depth beyond capacity");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> (iss_r <= depth_r))
    else $error("dump walk beyond stack depth");

  // The depth only changes when a request is taken.
  a_depth_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> (depth_r == $past(depth_r)))
    else $error("depth changed during a multi-cycle operation");

  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_func == OP_PUSH) && (depth_r < DEPTH_FULL))
      |=> (depth_r == $past(depth_r) + ONE))
    else $error("accepted push did not grow the stack");

  a_pop_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (out_valid_r && out_last_r && (out_status_r == ST_OK)))
    else $error("pop word not presented after the read");

endmodule
